### design/cht_pkg.sv
// shared constants, codes and result word type for the chained hash table
`default_nettype none
package cht_pkg;

   localparam int NUM_BUCKETS_DEF  = 10;
   localparam int BUCKET_DEPTH_DEF = 8;
   localparam int QUEUE_DEPTH      = 2;

   localparam int KEY_WIDTH        = 32;
   localparam int BUCKET_OUT_WIDTH = 4;
   localparam int SLOT_OUT_WIDTH   = 3;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef struct packed {
      logic [BUCKET_OUT_WIDTH-1:0] bucket;
      logic [SLOT_OUT_WIDTH-1:0]   slot;
      logic                        found;
      logic                        full_res;
   } result_type;

endpackage
`default_nettype wire

### design/cht_fifo.sv
// small register queue with push/full and pop/empty sides
`default_nettype none
module cht_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cht_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rdata,
   output logic                  empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count above depth");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> !empty)
      else $error("queue empty after a push");

endmodule
`default_nettype wire

### design/cht_front.sv
// front end: takes a request and works out its bucket by reciprocal multiplication
`default_nettype none
module cht_front #(
   parameter int NUM_BUCKETS = cht_pkg::NUM_BUCKETS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              hold,
   input  wire logic                              push,
   input  wire logic                              mode,
   input  wire logic [cht_pkg::KEY_WIDTH-1:0]     key,
   output logic                                   full,
   output logic                                   out_push,
   input  wire logic                              out_full,
   output logic                                   out_mode,
   output logic [cht_pkg::KEY_WIDTH-1:0]          out_key,
   output logic [$clog2(NUM_BUCKETS)-1:0]         out_bucket
);

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int KW = cht_pkg::KEY_WIDTH;
   localparam int PW = 2 * KW + 1;
   localparam int SH = KW + BW;
   localparam logic [BW:0]   MODULUS = (BW + 1)'(NUM_BUCKETS);
   localparam logic [KW-1:0] DIVISOR = KW'(NUM_BUCKETS);
   localparam logic [KW:0]   RECIP   =
      (KW + 1)'(((64'd1 << SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SUB, ST_SEND} state_type;

   state_type     state_ff;
   logic          mode_ff;
   logic [KW-1:0] key_ff;
   logic [KW-1:0] quot_ff;
   logic [KW-1:0] quot_in;
   logic [BW-1:0] rem_ff;
   logic [BW-1:0] rem_in;
   logic [PW-1:0] product;
   logic [KW-1:0] scaled;
   logic [KW-1:0] diff;
   logic          accept;

   assign full       = (state_ff != ST_IDLE) || hold;
   assign accept     = push && !full;
   assign out_push   = (state_ff == ST_SEND) && !out_full;
   assign out_mode   = mode_ff;
   assign out_key    = key_ff;
   assign out_bucket = rem_ff;

   // rounded-up reciprocal gives the exact quotient for every key
   assign product = PW'(key_ff) * PW'(RECIP);
   assign quot_in = KW'(product >> SH);
   assign scaled  = quot_ff * DIVISOR;
   assign diff    = key_ff - scaled;
   assign rem_in  = diff[BW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: state_ff <= ST_SUB;
            ST_SUB: state_ff <= ST_SEND;
            ST_SEND: begin
               if (!out_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= mode;
         key_ff  <= key;
      end
      if (state_ff == ST_MUL) begin
         quot_ff <= quot_in;
      end
      if (state_ff == ST_SUB) begin
         rem_ff <= rem_in;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> full)
      else $error("front took a second word while busy");

   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND) |-> ({1'b0, rem_ff} < MODULUS))
      else $error("bucket index out of range");

endmodule
`default_nettype wire

### design/cht_back.sv
// back end: bucket rows and fill counts, insert and search execution
`default_nettype none
module cht_back #(
   parameter int NUM_BUCKETS  = cht_pkg::NUM_BUCKETS_DEF,
   parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   output logic                                   clearing,
   input  wire logic                              in_empty,
   output logic                                   in_pop,
   input  wire logic                              in_mode,
   input  wire logic [cht_pkg::KEY_WIDTH-1:0]     in_key,
   input  wire logic [$clog2(NUM_BUCKETS)-1:0]    in_bucket,
   input  wire logic                              out_full,
   output logic                                   out_push,
   output cht_pkg::result_type                    out_word
);

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int KW = cht_pkg::KEY_WIDTH;
   localparam int SW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int FW = $clog2(BUCKET_DEPTH + 1);
   localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);
   localparam logic [FW-1:0] DEPTH_FILL  = FW'(BUCKET_DEPTH);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_MATCH, ST_DONE} state_type;

   logic [BUCKET_DEPTH-1:0][KW-1:0] key_mem [NUM_BUCKETS];
   logic [FW-1:0]                   fill_mem [NUM_BUCKETS];

   state_type                       state_ff;
   logic [BW-1:0]                   clr_ff;
   logic                            mode_ff;
   logic [KW-1:0]                   key_ff;
   logic [BW-1:0]                   bucket_ff;
   logic [BUCKET_DEPTH-1:0][KW-1:0] row_ff;
   logic [FW-1:0]                   fill_ff;
   logic [BUCKET_DEPTH-1:0]         match_ff;
   logic [BUCKET_DEPTH-1:0]         match_in;

   logic          ins_ok;
   logic          wr_key;
   logic          fill_we;
   logic [BW-1:0] fill_addr;
   logic [FW-1:0] fill_data;
   logic          hit;
   logic [SW-1:0] hit_slot;

   assign clearing = (state_ff == ST_CLEAR);
   assign in_pop   = (state_ff == ST_IDLE) && !in_empty;
   assign out_push = (state_ff == ST_DONE) && !out_full;
   assign ins_ok   = (mode_ff == cht_pkg::MODE_INSERT) && (fill_ff < DEPTH_FILL);
   assign wr_key   = out_push && ins_ok;

   assign fill_we   = clearing || wr_key;
   assign fill_addr = clearing ? clr_ff : bucket_ff;
   assign fill_data = clearing ? '0 : fill_ff + FW'(1);

   always_comb begin
      for (int i = 0; i < BUCKET_DEPTH; i++) begin
         match_in[i] = (FW'(i) < fill_ff) && (row_ff[i] == key_ff);
      end
   end

   // lowest matching slot wins
   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = BUCKET_DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit      = 1'b1;
            hit_slot = SW'(i);
         end
      end
   end

   always_comb begin
      out_word.bucket = cht_pkg::BUCKET_OUT_WIDTH'(bucket_ff);
      if (mode_ff == cht_pkg::MODE_INSERT) begin
         out_word.slot     = ins_ok ? cht_pkg::SLOT_OUT_WIDTH'(fill_ff[SW-1:0]) : '0;
         out_word.found    = 1'b0;
         out_word.full_res = !ins_ok;
      end else begin
         out_word.slot     = cht_pkg::SLOT_OUT_WIDTH'(hit_slot);
         out_word.found    = hit;
         out_word.full_res = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + BW'(1);
               if (clr_ff == LAST_BUCKET) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (!in_empty) begin
                  state_ff <= ST_MATCH;
               end
            end
            ST_MATCH: state_ff <= ST_DONE;
            ST_DONE: begin
               if (!out_full) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (in_pop) begin
         mode_ff   <= in_mode;
         key_ff    <= in_key;
         bucket_ff <= in_bucket;
      end
      if (state_ff == ST_MATCH) begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_pop) begin
         row_ff  <= key_mem[in_bucket];
         fill_ff <= fill_mem[in_bucket];
      end
      if (wr_key) begin
         key_mem[bucket_ff][fill_ff[SW-1:0]] <= key_ff;
      end
      if (fill_we) begin
         fill_mem[fill_addr] <= fill_data;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH) |-> (fill_ff <= DEPTH_FILL))
      else $error("bucket fill count above depth");

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !in_pop)
      else $error("work taken during clearing pass");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_full) |=>
         (state_ff == ST_DONE) && $stable(key_ff) && $stable(bucket_ff))
      else $error("result lost while output queue full");

endmodule
`default_nettype wire

### design/chained_hash_table.sv
// a request word goes through the front, the middle queue, the back and the response queue;
// the front takes no new word until it has sent the last (accept, multiply, remainder, send)
// and stalls on a full middle queue; the back steps through row and fill read, slot compare,
// encode and write back; reset: synchronous, then a clearing pass zeroes the fill counts
// and req_full stays high until it ends; key slots are never cleared
`default_nettype none
module chained_hash_table #(
   parameter int NUM_BUCKETS  = cht_pkg::NUM_BUCKETS_DEF,
   parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   output logic                                       req_full,
   input  wire logic                                  req_mode,
   input  wire logic [cht_pkg::KEY_WIDTH-1:0]         req_key,
   input  wire logic                                  rsp_pop,
   output logic                                       rsp_empty,
   output logic [cht_pkg::BUCKET_OUT_WIDTH-1:0]       rsp_bucket,
   output logic [cht_pkg::SLOT_OUT_WIDTH-1:0]         rsp_slot,
   output logic                                       rsp_found,
   output logic                                       rsp_full_res
);

   localparam int BW   = $clog2(NUM_BUCKETS);
   localparam int KW   = cht_pkg::KEY_WIDTH;
   localparam int MIDW = 1 + KW + BW;
   localparam int RSPW = $bits(cht_pkg::result_type);

   logic            clearing;
   logic            f_push;
   logic            f_mode;
   logic [KW-1:0]   f_key;
   logic [BW-1:0]   f_bucket;
   logic            mid_full;
   logic            mid_empty;
   logic            mid_pop;
   logic [MIDW-1:0] mid_wdata;
   logic [MIDW-1:0] mid_rdata;

   logic                b_push;
   logic                rsp_full;
   cht_pkg::result_type b_word;
   cht_pkg::result_type rsp_word;
   logic [RSPW-1:0]     rsp_rdata;

   cht_front #(
      .NUM_BUCKETS(NUM_BUCKETS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (clearing),
      .push       (req_push),
      .mode       (req_mode),
      .key        (req_key),
      .full       (req_full),
      .out_push   (f_push),
      .out_full   (mid_full),
      .out_mode   (f_mode),
      .out_key    (f_key),
      .out_bucket (f_bucket)
   );

   assign mid_wdata = {f_mode, f_key, f_bucket};

   cht_fifo #(
      .WIDTH(MIDW),
      .DEPTH(cht_pkg::QUEUE_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   cht_back #(
      .NUM_BUCKETS  (NUM_BUCKETS),
      .BUCKET_DEPTH (BUCKET_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .in_empty  (mid_empty),
      .in_pop    (mid_pop),
      .in_mode   (mid_rdata[MIDW-1]),
      .in_key    (mid_rdata[MIDW-2 -: KW]),
      .in_bucket (mid_rdata[BW-1:0]),
      .out_full  (rsp_full),
      .out_push  (b_push),
      .out_word  (b_word)
   );

   cht_fifo #(
      .WIDTH(RSPW),
      .DEPTH(cht_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (b_push),
      .wdata (b_word),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .rdata (rsp_rdata),
      .empty (rsp_empty)
   );

   assign rsp_word     = rsp_rdata;
   assign rsp_bucket   = rsp_word.bucket;
   assign rsp_slot     = rsp_word.slot;
   assign rsp_found    = rsp_word.found;
   assign rsp_full_res = rsp_word.full_res;

endmodule
`default_nettype wire

### sim/chained_hash_table_test.sv
// self-checking testbench for the chained hash table: queued request words, predicted responses
module chained_hash_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BUCKETS  = cht_pkg::NUM_BUCKETS_DEF;
   localparam int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF;
   localparam int KW           = cht_pkg::KEY_WIDTH;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_AT      = 950;
   localparam int HOLD_CYCLES  = 250;

   typedef struct {
      logic          mode;
      logic [KW-1:0] key;
   } req_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic req_mode = cht_pkg::MODE_INSERT;
   logic [KW-1:0] req_key = '0;
   logic rsp_pop = 1'b0;
   logic rsp_empty;
   logic [cht_pkg::BUCKET_OUT_WIDTH-1:0] rsp_bucket;
   logic [cht_pkg::SLOT_OUT_WIDTH-1:0] rsp_slot;
   logic rsp_found;
   logic rsp_full_res;

   req_word_type req_words[$];
   cht_pkg::result_type awaited_words[$];
   logic [KW-1:0] offered_keys[$];

   logic [KW-1:0] table_keys[NUM_BUCKETS][BUCKET_DEPTH];
   int unsigned table_fill[NUM_BUCKETS] = '{default: 0};

   int sender_idle_pct = 29;
   int receiver_idle_pct = 60;
   int error_count = 0;
   int results_seen = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int n_inserts = 0;
   int n_rejected = 0;
   int n_hits = 0;
   int n_misses = 0;

   chained_hash_table u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_mode    (req_mode),
      .req_key     (req_key),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_bucket  (rsp_bucket),
      .rsp_slot    (rsp_slot),
      .rsp_found   (rsp_found),
      .rsp_full_res(rsp_full_res)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      error_count++;
      $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic apply_table_op(input req_word_type w);
      cht_pkg::result_type r;
      int unsigned b;
      int unsigned n;
      r = '0;
      b = w.key % NUM_BUCKETS;
      n = table_fill[b];
      r.bucket = cht_pkg::BUCKET_OUT_WIDTH'(b);
      if (w.mode == cht_pkg::MODE_INSERT) begin
         n_inserts++;
         if (n >= BUCKET_DEPTH) begin
            r.full_res = 1'b1;
            n_rejected++;
         end else begin
            table_keys[b][n] = w.key;
            table_fill[b] = n + 1;
            r.slot = cht_pkg::SLOT_OUT_WIDTH'(n);
         end
      end else begin
         for (int i = 0; i < n; i++) begin
            if (!r.found && table_keys[b][i] == w.key) begin
               r.found = 1'b1;
               r.slot = cht_pkg::SLOT_OUT_WIDTH'(i);
            end
         end
         if (r.found) n_hits++;
         else n_misses++;
      end
      awaited_words.push_back(r);
   endtask

   task automatic add_word(input logic mode, input logic [KW-1:0] key);
      req_word_type w;
      w.mode = mode;
      w.key = key;
      req_words.push_back(w);
      if (mode == cht_pkg::MODE_INSERT) offered_keys.push_back(key);
   endtask

   task automatic add_random_words(input int count);
      int pick;
      logic [KW-1:0] known;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         known = offered_keys[$urandom_range(offered_keys.size() - 1)];
         if (pick < 12) add_word(cht_pkg::MODE_INSERT, $urandom);
         else if (pick < 16) add_word(cht_pkg::MODE_INSERT, known);
         else if (pick < 60) add_word(cht_pkg::MODE_SEARCH, known);
         else if (pick < 85) add_word(cht_pkg::MODE_SEARCH, $urandom);
         else add_word(cht_pkg::MODE_SEARCH, known + KW'(NUM_BUCKETS));
      end
   endtask

   task automatic drain_all();
      while (req_words.size() != 0 || awaited_words.size() != 0) @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            apply_table_op(req_words.pop_front());
         end
         if (!(req_push && req_full)) begin
            if (req_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_push <= 1'b1;
               req_mode <= req_words[0].mode;
               req_key <= req_words[0].key;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cht_pkg::result_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (awaited_words.size() == 0) begin
               report_mismatch("unexpected word",
                               64'({rsp_bucket, rsp_slot, rsp_found, rsp_full_res}), 64'd0);
            end else begin
               want = awaited_words.pop_front();
               if (rsp_bucket !== want.bucket) begin
                  report_mismatch("bucket", 64'(rsp_bucket), 64'(want.bucket));
               end
               if (rsp_slot !== want.slot) begin
                  report_mismatch("slot", 64'(rsp_slot), 64'(want.slot));
               end
               if (rsp_found !== want.found) begin
                  report_mismatch("found", 64'(rsp_found), 64'(want.found));
               end
               if (rsp_full_res !== want.full_res) begin
                  report_mismatch("full_res", 64'(rsp_full_res), 64'(want.full_res));
               end
            end
            if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("chained_hash_table_test: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty bucket, both key extremes, a full bucket with a duplicate
      add_word(cht_pkg::MODE_SEARCH, 32'd0);
      add_word(cht_pkg::MODE_INSERT, 32'd0);
      add_word(cht_pkg::MODE_SEARCH, 32'd0);
      add_word(cht_pkg::MODE_INSERT, 32'hFFFF_FFFF);
      add_word(cht_pkg::MODE_SEARCH, 32'hFFFF_FFFF);
      add_word(cht_pkg::MODE_SEARCH, 32'hFFFF_FFF5);
      add_word(cht_pkg::MODE_INSERT, 32'd5);
      add_word(cht_pkg::MODE_INSERT, 32'd15);
      add_word(cht_pkg::MODE_INSERT, 32'd5);
      add_word(cht_pkg::MODE_INSERT, 32'd25);
      add_word(cht_pkg::MODE_INSERT, 32'd35);
      add_word(cht_pkg::MODE_INSERT, 32'd45);
      add_word(cht_pkg::MODE_INSERT, 32'd55);
      add_word(cht_pkg::MODE_INSERT, 32'd65);
      add_word(cht_pkg::MODE_SEARCH, 32'd5);
      add_word(cht_pkg::MODE_SEARCH, 32'd55);
      add_word(cht_pkg::MODE_SEARCH, 32'd65);
      add_word(cht_pkg::MODE_INSERT, 32'd10);
      add_word(cht_pkg::MODE_SEARCH, 32'd10);
      add_word(cht_pkg::MODE_INSERT, 32'h8000_0000);
      add_word(cht_pkg::MODE_SEARCH, 32'h7FFF_FFFF);
      drain_all();

      add_random_words(400);
      drain_all();

      sender_idle_pct = 60;
      receiver_idle_pct = 29;
      add_random_words(400);
      drain_all();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      add_random_words(400);
      drain_all();

      repeat (40) @(posedge clock);
      $display("covered %0d inserts (%0d rejected on a full bucket),", n_inserts, n_rejected);
      $display("%0d searches (%0d hits, %0d misses), %0d response words checked",
               n_hits + n_misses, n_hits, n_misses, results_seen);
      if (error_count == 0) begin
         $display("chained_hash_table_test: clean");
      end else begin
         $display("chained_hash_table_test: errors");
      end
      $finish;
   end

endmodule
